// ----- hdl/bbr_pkg.sv -----
`timescale 1ns / 1ps
// ============================================================================
// bbr_pkg
// Shared types and constants of the 3x3 RGBA box blur.
// ============================================================================
package bbr_pkg;

    localparam int CFG_W       = 11;
    localparam int PIX_W       = 32;
    localparam int CH_W        = 8;
    localparam int RGB_W       = 3 * CH_W;
    localparam int SUM_W       = 12;
    localparam int RECIP_W     = 13;
    localparam int PROD_W      = SUM_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP9 = 13'd7282;
    localparam int RECIP_SHIFT = 16;
    localparam logic [CH_W-1:0] ALPHA = 8'hFF;

    localparam int FIFO_DEPTH  = 4;
    localparam int FIFO_AW     = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW     = $clog2(FIFO_DEPTH + 1);

    typedef enum logic [0:0] {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } t_reg_idx;

    typedef logic [RGB_W-1:0] t_rgb;

    typedef struct packed {
        t_rgb up2;
        t_rgb up1;
        t_rgb cur;
        logic clear;
        logic emit;
        logic last;
    } t_col_item;

endpackage

// ----- hdl/bbr_ram.sv -----
`timescale 1ns / 1ps
// ============================================================================
// bbr_ram
// Simple dual-port RAM, one write and one registered read port, read-first.
// ============================================================================
module bbr_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hdl/bbr_fifo.sv -----
`timescale 1ns / 1ps
// ============================================================================
// bbr_fifo
// Short queue of column items between the front and the back.
// ============================================================================
module bbr_fifo import bbr_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  t_col_item          i_item,
    input  logic               i_pop,
    output t_col_item          o_item,
    output logic               o_empty,
    output logic [FIFO_CW-1:0] o_count
);

    t_col_item            r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   r_wptr;
    logic [FIFO_AW-1:0]   r_rptr;
    logic [FIFO_CW-1:0]   r_count;
    logic [FIFO_CW-1:0]   n_count;

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_item;
        end
    end

    assign o_item  = r_mem[r_rptr];
    assign o_empty = (r_count == '0);
    assign o_count = r_count;

endmodule

// ----- hdl/bbr_front.sv -----
`timescale 1ns / 1ps
// ============================================================================
// bbr_front
// Input side: frame registers, padded position counters, line store access
// and classification of each transfer into a column item.
// ============================================================================
module bbr_front import bbr_pkg::*; #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  t_reg_idx           i_cfg_idx,
    input  logic [CFG_W-1:0]   i_cfg_data,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [PIX_W-1:0]   i_pixel,
    input  logic [FIFO_CW-1:0] i_fifo_count,
    output logic               o_push,
    output t_col_item          o_item
);

    localparam int WW  = $clog2(MAX_WIDTH + 1);
    localparam int HW  = $clog2(MAX_HEIGHT + 2);
    localparam int AW  = $clog2(MAX_WIDTH);
    localparam int CWW = (WW > CFG_W) ? WW : CFG_W;
    localparam int CHW = (HW + 1 > CFG_W) ? HW + 1 : CFG_W;

    logic [CFG_W-1:0] r_frame_width;
    logic [CFG_W-1:0] r_frame_height;
    logic [WW-1:0]    r_col;
    logic [HW-1:0]    r_row;
    logic [WW-1:0]    n_col;
    logic [HW-1:0]    n_row;

    logic [CWW-1:0]   w_ext;
    logic [CWW-1:0]   w_clamp;
    logic [WW-1:0]    w_eff;
    logic [CHW-1:0]   h_ext;
    logic [CHW-1:0]   h_eff;
    logic [CHW-1:0]   row_x;

    logic             accept;
    logic             in_col;
    logic             up2_ok;
    logic             up1_ok;
    logic             cur_ok;
    logic             emit;
    logic             last;
    t_rgb             rgb;
    logic [AW-1:0]    addr;
    t_rgb             q0;
    t_rgb             q1;

    logic             r_f1_valid;
    logic             r_f1_bank;
    logic             r_f1_up2_ok;
    logic             r_f1_up1_ok;
    logic             r_f1_cur_ok;
    logic             r_f1_clear;
    logic             r_f1_emit;
    logic             r_f1_last;
    t_rgb             r_f1_rgb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= CFG_W'(800);
            r_frame_height <= CFG_W'(600);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data;
                REG_FRAME_HEIGHT: r_frame_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // clamp dimensions to 1..MAX
    always_comb begin
        w_ext = CWW'(r_frame_width);
        if (w_ext == '0) begin
            w_clamp = CWW'(1);
        end else if (w_ext > CWW'(MAX_WIDTH)) begin
            w_clamp = CWW'(MAX_WIDTH);
        end else begin
            w_clamp = w_ext;
        end
        w_eff = w_clamp[WW-1:0];

        h_ext = CHW'(r_frame_height);
        if (h_ext == '0) begin
            h_eff = CHW'(1);
        end else if (h_ext > CHW'(MAX_HEIGHT)) begin
            h_eff = CHW'(MAX_HEIGHT);
        end else begin
            h_eff = h_ext;
        end
    end

    assign o_ready = ({1'b0, i_fifo_count} + (FIFO_CW + 1)'(r_f1_valid))
                     < (FIFO_CW + 1)'(FIFO_DEPTH);
    assign accept  = i_valid && o_ready;
    assign rgb     = i_pixel[PIX_W-1 -: RGB_W];
    assign addr    = r_col[AW-1:0];
    assign row_x   = CHW'(r_row);

    always_comb begin
        in_col = r_col < w_eff;
        up2_ok = in_col && (row_x >= CHW'(2)) && (row_x < h_eff + CHW'(2));
        up1_ok = in_col && (r_row != '0) && (row_x <= h_eff);
        cur_ok = in_col && (row_x < h_eff);
        emit   = (r_col != '0) && (r_row != '0) && (r_col <= w_eff) && (row_x <= h_eff);
        last   = (r_col == w_eff) && (row_x == h_eff);

        if (r_col >= w_eff) begin
            n_col = '0;
            n_row = (row_x >= h_eff) ? '0 : HW'(r_row + 1'b1);
        end else begin
            n_col = WW'(r_col + 1'b1);
            n_row = (row_x > h_eff) ? '0 : r_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_f1_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_col <= n_col;
                r_row <= n_row;
            end
            r_f1_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_f1_bank   <= r_row[0];
            r_f1_up2_ok <= up2_ok;
            r_f1_up1_ok <= up1_ok;
            r_f1_cur_ok <= cur_ok;
            r_f1_clear  <= (r_col == '0);
            r_f1_emit   <= emit;
            r_f1_last   <= last;
            r_f1_rgb    <= rgb;
        end
    end

    // line banks selected by row parity
    bbr_ram #(
        .WIDTH (RGB_W),
        .DEPTH (MAX_WIDTH)
    ) u_bank0 (
        .i_clk   (i_clk),
        .i_we    (accept && cur_ok && !r_row[0]),
        .i_waddr (addr),
        .i_wdata (rgb),
        .i_raddr (addr),
        .o_rdata (q0)
    );

    bbr_ram #(
        .WIDTH (RGB_W),
        .DEPTH (MAX_WIDTH)
    ) u_bank1 (
        .i_clk   (i_clk),
        .i_we    (accept && cur_ok && r_row[0]),
        .i_waddr (addr),
        .i_wdata (rgb),
        .i_raddr (addr),
        .o_rdata (q1)
    );

    always_comb begin
        o_item.up2   = r_f1_up2_ok ? (r_f1_bank ? q1 : q0) : '0;
        o_item.up1   = r_f1_up1_ok ? (r_f1_bank ? q0 : q1) : '0;
        o_item.cur   = r_f1_cur_ok ? r_f1_rgb : '0;
        o_item.clear = r_f1_clear;
        o_item.emit  = r_f1_emit;
        o_item.last  = r_f1_last;
    end

    assign o_push = r_f1_valid;

endmodule

// ----- hdl/bbr_back.sv -----
`timescale 1ns / 1ps
// ============================================================================
// bbr_back
// Output side: 3x3 window, channel sums, divide by nine, output register.
// ============================================================================
module bbr_back import bbr_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_empty,
    input  t_col_item        i_item,
    output logic             o_pop,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [PIX_W-1:0] o_pixel,
    output logic             o_last
);

    t_rgb              r_win [3][3];
    logic              r_a_valid;
    logic              r_a_last;
    logic              r_b_valid;
    logic              r_b_last;
    logic [SUM_W-1:0]  r_b_sum [3];
    logic              r_o_valid;
    logic              r_o_last;
    logic [PIX_W-1:0]  r_o_pixel;

    logic              ready_o;
    logic              ready_b;
    logic              ready_a;
    logic [SUM_W-1:0]  sum [3];
    logic [PROD_W-1:0] prod [3];

    assign ready_o = !r_o_valid || i_ready;
    assign ready_b = !r_b_valid || ready_o;
    assign ready_a = !r_a_valid || ready_b;
    assign o_pop   = !i_empty && ready_a;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r_win[i][j] <= '0;
                end
            end
        end else if (o_pop) begin
            for (int i = 0; i < 3; i++) begin
                r_win[i][0] <= i_item.clear ? '0 : r_win[i][1];
                r_win[i][1] <= i_item.clear ? '0 : r_win[i][2];
            end
            r_win[0][2] <= i_item.up2;
            r_win[1][2] <= i_item.up1;
            r_win[2][2] <= i_item.cur;
        end
    end

    // per channel: 0 red, 1 green, 2 blue
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            sum[k] = '0;
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    sum[k] = sum[k] + SUM_W'(r_win[i][j][(2-k)*CH_W +: CH_W]);
                end
            end
        end
        for (int k = 0; k < 3; k++) begin
            prod[k] = PROD_W'(r_b_sum[k]) * PROD_W'(RECIP9);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (ready_a) begin
                r_a_valid <= o_pop && i_item.emit;
            end
            if (ready_b) begin
                r_b_valid <= r_a_valid;
            end
            if (ready_o) begin
                r_o_valid <= r_b_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready_a) begin
            r_a_last <= i_item.last;
        end
        if (ready_b) begin
            r_b_last <= r_a_last;
            for (int k = 0; k < 3; k++) begin
                r_b_sum[k] <= sum[k];
            end
        end
        if (ready_o) begin
            r_o_last  <= r_b_last;
            r_o_pixel <= {prod[0][RECIP_SHIFT +: CH_W], prod[1][RECIP_SHIFT +: CH_W],
                          prod[2][RECIP_SHIFT +: CH_W], ALPHA};
        end
    end

    assign o_valid = r_o_valid;
    assign o_pixel = r_o_pixel;
    assign o_last  = r_o_last;

endmodule

// ----- hdl/box_blur_3x3_rgba.sv -----
`timescale 1ns / 1ps
// ============================================================================
// box_blur_3x3_rgba
// Streaming 3x3 box blur over RGBA8888 pixels in raster order.
// ============================================================================
// Each input row carries frame_width pixels plus one padding transfer, and
// one full padding row follows the frame. One pixel per clock is taken in
// sustained operation: the front takes a transfer whenever the four-entry
// queue plus its own stage still has room, so while the sink takes every
// output the input never stalls; sink stalls back up through the queue. Each
// transfer at padded position (c>=1, r>=1) yields the blurred pixel
// (c-1, r-1), so a frame gives width*height results, the last one flagged by
// tlast. Between the input transfer that completes an output pixel and that
// pixel, the line store read, queue, window, channel sums and divide by nine
// each take one register, in that order.
// Two line banks of MAX_WIDTH entries hold the previous two rows. Pixels
// outside the frame count as zero, every sum is divided by nine and alpha
// is forced to 0xFF. Write frame_width and frame_height only while idle.
// ============================================================================
module box_blur_3x3_rgba import bbr_pkg::*; #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  t_reg_idx         i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_data,
    input  logic             i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  logic [31:0]      i_s_axis_tdata,   // [31:0] in_pixel
    output logic             o_m_axis_tvalid,
    input  logic             i_m_axis_tready,
    output logic [31:0]      o_m_axis_tdata,   // [31:0] out_pixel
    output logic             o_m_axis_tlast
);

    logic               push;
    logic               pop;
    logic               empty;
    logic [FIFO_CW-1:0] fifo_count;
    t_col_item          front_item;
    t_col_item          back_item;

    bbr_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_valid      (i_s_axis_tvalid),
        .o_ready      (o_s_axis_tready),
        .i_pixel      (i_s_axis_tdata),
        .i_fifo_count (fifo_count),
        .o_push       (push),
        .o_item       (front_item)
    );

    bbr_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .i_pop   (pop),
        .o_item  (back_item),
        .o_empty (empty),
        .o_count (fifo_count)
    );

    bbr_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .i_item  (back_item),
        .o_pop   (pop),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_pixel (o_m_axis_tdata),
        .o_last  (o_m_axis_tlast)
    );

endmodule
